### sv/accel_tilt_angle_defines.svh
// Assertion macros used by the checker file.
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define ATA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define ATA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ata_pkg.sv
`default_nettype none

package ata_pkg;

  // Field widths at the ports
  localparam int FIELD_W = 16;
  localparam int ANGLE_W = 16;

  // Normalisation: big << 2k reaches bit NORM_TOP, k at most K_MAX
  localparam int NORM_TOP = 58;
  localparam int K_MAX    = 29;
  localparam int K_W      = 5;
  localparam int CHUNK_W  = 8;

  // Square root: radicand below 2^60, root below 2^30
  localparam int RAD_W  = 60;
  localparam int ROOT_W = 30;

  // CORDIC: angles in 1/2^ZBITS degree
  localparam int ZBITS        = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 34;
  localparam int ZW           = 29;
  localparam int ATAN_W       = 27;

  localparam int RIGHT_ANGLE = 90;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic inv;    // axis select invalid
    logic mzero;  // chosen axis is zero
    logic szero;  // other two axes both zero
    logic neg;    // chosen axis negative
  } flags_t;

  // atan(2^-i) in degrees, scaled by 2^ZBITS
  localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

endpackage

`default_nettype wire

### sv/accel_tilt_angle.sv
`default_nettype none

// Tilt angle of one accelerometer axis against the plane of the other two, in
// signed 1/2^ANGLE_FRAC_BITS degree, rounded half up, within one LSB of the
// exact atan(a / sqrt(b*b + c*c)). One sample is taken every cycle while
// sample_stall is low; each result passes through seven front stages
// (input, axis select, squares, sum, two leading-one stages, normalising
// shift), thirty square-root stages that settle one root bit each, twenty-four
// CORDIC stages of one rotation each, one rounding stage and the output
// register. A skid register behind the output lets the pipeline run on for
// one beat when the sink stalls; sample_stall rises only while that skid
// register is full. An invalid axis select returns angle 0 with axis_valid
// low. Reset clears the valid flags; the block holds no state between samples.
module accel_tilt_angle
  import ata_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [FIELD_W-1:0] accel_x,
  input  logic signed [FIELD_W-1:0] accel_y,
  input  logic signed [FIELD_W-1:0] accel_z,
  input  logic [1:0]                opcode,
  output logic                      angle_valid,
  input  logic                      angle_stall,
  output logic signed [ANGLE_W-1:0] tilt_angle,
  output logic                      axis_valid
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int NCH    = (SQ_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = NCH * CHUNK_W;
  localparam int MSB_W  = $clog2(PAD_W);
  localparam int LOC_W  = $clog2(CHUNK_W);
  localparam int TW     = RAD_W + 2;
  localparam int RND_SH = ZBITS - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (RND_SH - 1));
  localparam logic signed [ZW-1:0] FULL_ANG   = ZW'(RIGHT_ANGLE << ANGLE_FRAC_BITS);

  // Low SAMPLE_BITS of a port field, read as signed (zero-extended if wider than the field)
  function automatic logic signed [SB-1:0] take_sample(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W+SB-1:0] ext;
    ext = {{SB{1'b0}}, raw};
    return $signed(ext[SB-1:0]);
  endfunction

  logic adv;
  logic skid_valid;

  // Whole pipeline advances while the skid register is free
  assign adv          = !skid_valid;
  assign sample_stall = skid_valid;

  // ---------------------------------------------------------------- input
  logic                 s0_valid;
  logic signed [SB-1:0] s0_x, s0_y, s0_z;
  axis_t                s0_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x   <= take_sample(accel_x);
      s0_y   <= take_sample(accel_y);
      s0_z   <= take_sample(accel_z);
      s0_sel <= axis_t'(opcode);
    end
  end

  // ---------------------------------------------------------- axis select
  logic signed [SB-1:0] sel_a, sel_b, sel_c;
  logic [SB-1:0]        sel_ua;
  logic                 s1_valid;
  logic signed [SB-1:0] s1_b, s1_c;
  logic [SB-1:0]        s1_m;
  flags_t               s1_f;

  always_comb begin
    unique case (s0_sel)
      AXIS_X: begin
        sel_a = s0_x; sel_b = s0_y; sel_c = s0_z;
      end
      AXIS_Y: begin
        sel_a = s0_y; sel_b = s0_x; sel_c = s0_z;
      end
      AXIS_Z: begin
        sel_a = s0_z; sel_b = s0_y; sel_c = s0_x;
      end
      AXIS_NONE: begin
        sel_a = s0_x; sel_b = s0_y; sel_c = s0_z;
      end
    endcase
    sel_ua = sel_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_b       <= sel_b;
      s1_c       <= sel_c;
      s1_m       <= sel_ua[SB-1] ? (~sel_ua + SB'(1)) : sel_ua;
      s1_f.inv   <= (s0_sel == AXIS_NONE);
      s1_f.mzero <= (sel_ua == '0);
      s1_f.szero <= 1'b0;
      s1_f.neg   <= sel_ua[SB-1];
    end
  end

  // -------------------------------------------------------------- squares
  logic signed [SQ_W-1:0] sq_bb, sq_cc;
  logic                   s2_valid;
  logic [SQ_W-1:0]        s2_bb, s2_cc, s2_mm;
  logic [SB-1:0]          s2_m;
  flags_t                 s2_f;

  assign sq_bb = s1_b * s1_b;
  assign sq_cc = s1_c * s1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_bb <= sq_bb;
      s2_cc <= sq_cc;
      s2_mm <= SQ_W'(s1_m) * SQ_W'(s1_m);
      s2_m  <= s1_m;
      s2_f  <= s1_f;
    end
  end

  // ------------------------------------------------- sum and larger square
  logic [SQ_W-1:0] sum_s;
  logic            s3_valid;
  logic [SQ_W-1:0] s3_s, s3_big;
  logic [SB-1:0]   s3_m;
  flags_t          s3_f;

  assign sum_s = s2_bb + s2_cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_s   <= sum_s;
      s3_big <= (s2_mm > sum_s) ? s2_mm : sum_s;
      s3_m   <= s2_m;
      s3_f   <= '{inv: s2_f.inv, mzero: s2_f.mzero, szero: (sum_s == '0),
                  neg: s2_f.neg};
    end
  end

  // ------------------------------------------ leading one, per byte chunk
  logic [PAD_W-1:0] big_pad;
  logic [NCH-1:0]   chunk_nz;
  logic [LOC_W-1:0] chunk_loc [0:NCH-1];
  logic             s4_valid;
  logic [NCH-1:0]   s4_nz;
  logic [LOC_W-1:0] s4_loc [0:NCH-1];
  logic [SQ_W-1:0]  s4_s;
  logic [SB-1:0]    s4_m;
  flags_t           s4_f;

  assign big_pad = PAD_W'(s3_big);

  always_comb begin
    for (int j = 0; j < NCH; j++) begin
      chunk_nz[j]  = |big_pad[j*CHUNK_W +: CHUNK_W];
      chunk_loc[j] = '0;
      for (int l = 0; l < CHUNK_W; l++) begin
        if (big_pad[j*CHUNK_W + l]) begin
          chunk_loc[j] = LOC_W'(l);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nz  <= chunk_nz;
      s4_loc <= chunk_loc;
      s4_s   <= s3_s;
      s4_m   <= s3_m;
      s4_f   <= s3_f;
    end
  end

  // ------------------------------------------ combine chunks, shift count
  logic [MSB_W-1:0] lead_msb;
  logic [K_W-1:0]   norm_k;
  logic             s5_valid;
  logic [K_W-1:0]   s5_k;
  logic [SQ_W-1:0]  s5_s;
  logic [SB-1:0]    s5_m;
  flags_t           s5_f;

  always_comb begin
    lead_msb = '0;
    for (int j = 0; j < NCH; j++) begin
      if (s4_nz[j]) begin
        lead_msb = MSB_W'(j * CHUNK_W) + MSB_W'(s4_loc[j]);
      end
    end
    // Smallest k that lifts the leading one to NORM_TOP or one above
    if (|s4_nz) begin
      norm_k = K_W'((NORM_TOP + 1 - int'(lead_msb)) >> 1);
    end else begin
      norm_k = K_W'(K_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_k <= norm_k;
      s5_s <= s4_s;
      s5_m <= s4_m;
      s5_f <= s4_f;
    end
  end

  // ------------------------------------------------------ normalise shift
  logic              s6_valid;
  logic [RAD_W-1:0]  s6_rad;
  logic [ROOT_W-1:0] s6_y;
  flags_t            s6_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_rad <= RAD_W'(s5_s) << {s5_k, 1'b0};
      s6_y   <= ROOT_W'(s5_m) << s5_k;
      s6_f   <= s5_f;
    end
  end

  // ------------------------------------------- square root, a bit a stage
  logic              sq_valid [0:ROOT_W-1];
  logic [RAD_W-1:0]  sq_rem   [0:ROOT_W-1];
  logic [ROOT_W-1:0] sq_root  [0:ROOT_W-1];
  logic [ROOT_W-1:0] sq_y     [0:ROOT_W-1];
  flags_t            sq_f     [0:ROOT_W-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int BI = ROOT_W - 1 - j;
    logic              v_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [ROOT_W-1:0] y_in;
    flags_t            f_in;
    logic [TW-1:0]     trial;
    logic [TW-1:0]     rem_ext;
    logic              fits;

    if (j == 0) begin : g_first
      assign v_in    = s6_valid;
      assign rem_in  = s6_rad;
      assign root_in = '0;
      assign y_in    = s6_y;
      assign f_in    = s6_f;
    end else begin : g_rest
      assign v_in    = sq_valid[j-1];
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign y_in    = sq_y[j-1];
      assign f_in    = sq_f[j-1];
    end

    // (q + 2^i)^2 - q^2, with q holding only bits above i
    assign trial   = (TW'(root_in) << (BI + 1)) | (TW'(1) << (2 * BI));
    assign rem_ext = TW'(rem_in);
    assign fits    = (rem_ext >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j] <= 1'b0;
      end else if (adv) begin
        sq_valid[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[j]  <= fits ? RAD_W'(rem_ext - trial) : rem_in;
        sq_root[j] <= fits ? (root_in | (ROOT_W'(1) << BI)) : root_in;
        sq_y[j]    <= y_in;
        sq_f[j]    <= f_in;
      end
    end
  end

  // --------------------------------------- vectoring CORDIC, a step a stage
  logic                 cd_valid [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] cd_x     [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] cd_y     [0:CORDIC_STEPS-1];
  logic signed [ZW-1:0] cd_z     [0:CORDIC_STEPS-1];
  flags_t               cd_f     [0:CORDIC_STEPS-1];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic                 v_in;
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, step;
    flags_t               f_in;

    if (i == 0) begin : g_first
      assign v_in = sq_valid[ROOT_W-1];
      assign x_in = $signed(CW'(sq_root[ROOT_W-1]));
      assign y_in = $signed(CW'(sq_y[ROOT_W-1]));
      assign z_in = '0;
      assign f_in = sq_f[ROOT_W-1];
    end else begin : g_rest
      assign v_in = cd_valid[i-1];
      assign x_in = cd_x[i-1];
      assign y_in = cd_y[i-1];
      assign z_in = cd_z[i-1];
      assign f_in = cd_f[i-1];
    end

    assign dx   = y_in >>> i;
    assign dy   = x_in >>> i;
    assign step = $signed(ZW'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_valid[i] <= 1'b0;
      end else if (adv) begin
        cd_valid[i] <= v_in;
      end
    end

    // Rotate towards the x axis, accumulating the angle turned
    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_in > 0) begin
          cd_x[i] <= x_in + dx;
          cd_y[i] <= y_in - dy;
          cd_z[i] <= z_in + step;
        end else begin
          cd_x[i] <= x_in - dx;
          cd_y[i] <= y_in + dy;
          cd_z[i] <= z_in - step;
        end
        cd_f[i] <= f_in;
      end
    end
  end

  // ------------------------------------------- round, clamp, special cases
  logic signed [ZW-1:0]      z_fin, z_rnd, z_q, ang_mag, ang;
  flags_t                    f_fin;
  logic                      rs_valid;
  logic signed [ANGLE_W-1:0] rs_tilt;
  logic                      rs_axis;

  assign z_fin = cd_z[CORDIC_STEPS-1];
  assign f_fin = cd_f[CORDIC_STEPS-1];
  assign z_rnd = z_fin + ROUND_HALF;
  assign z_q   = z_rnd >>> RND_SH;

  always_comb begin
    priority if (f_fin.inv || f_fin.mzero) begin
      ang_mag = '0;
    end else if (f_fin.szero) begin
      ang_mag = FULL_ANG;
    end else if (z_q < 0) begin
      ang_mag = '0;
    end else if (z_q > FULL_ANG) begin
      ang_mag = FULL_ANG;
    end else begin
      ang_mag = z_q;
    end
    ang = (f_fin.neg && !f_fin.inv) ? -ang_mag : ang_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid <= 1'b0;
    end else if (adv) begin
      rs_valid <= cd_valid[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_tilt <= ang[ANGLE_W-1:0];
      rs_axis <= !f_fin.inv;
    end
  end

  // --------------------------------------------- output and skid registers
  logic                      take, push;
  logic signed [ANGLE_W-1:0] skid_tilt;
  logic                      skid_axis;

  assign take = angle_valid && !angle_stall;
  assign push = adv && rs_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (angle_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        angle_valid <= 1'b1;
      end
    end else if (take) begin
      angle_valid <= 1'b0;
    end
  end

  // Drain the skid first; park a new beat there only while the output holds
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        tilt_angle <= skid_tilt;
        axis_valid <= skid_axis;
      end
    end else if (push) begin
      if (angle_valid && !take) begin
        skid_tilt <= rs_tilt;
        skid_axis <= rs_axis;
      end else begin
        tilt_angle <= rs_tilt;
        axis_valid <= rs_axis;
      end
    end
  end

endmodule

`default_nettype wire

### sv/ata_chk.sv
`default_nettype none

`include "accel_tilt_angle_defines.svh"

module ata_chk
  import ata_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      sample_stall,
  input wire logic                      angle_valid,
  input wire logic                      angle_stall,
  input wire logic signed [ANGLE_W-1:0] tilt_angle,
  input wire logic                      axis_valid
);

  localparam bit FULL_FITS = (RIGHT_ANGLE << ANGLE_FRAC_BITS) < (1 << (ANGLE_W - 1));
  localparam logic signed [ANGLE_W-1:0] FULL16 = ANGLE_W'(RIGHT_ANGLE << ANGLE_FRAC_BITS);

  // A held beat keeps its payload
  `ATA_ASSERT_NEXT(a_hold, clk, rst, angle_valid && angle_stall, angle_valid && $stable(tilt_angle) && $stable(axis_valid), "stalled result beat changed")

  // An invalid axis always reads as angle zero
  `ATA_ASSERT_IMPL(a_inv_zero, clk, rst, angle_valid && !axis_valid, tilt_angle == '0, "invalid axis with nonzero angle")

  // Input stalls only behind a full output that was stalled the cycle before
  `ATA_ASSERT_IMPL(a_stall_cause, clk, rst, sample_stall, angle_valid && $past(angle_stall), "input stalled without a stalled output")

  // Angle stays within plus or minus ninety degrees where it fits the field
  `ATA_ASSERT_IMPL(a_range, clk, rst, angle_valid && axis_valid, !FULL_FITS || (tilt_angle <= FULL16 && tilt_angle >= -FULL16), "tilt angle beyond ninety degrees")

endmodule

bind accel_tilt_angle ata_chk #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_chk (.*);

`default_nettype wire
